>>> design/fmwo_pkg.sv
// Shared widths, reset values and register indexes for the FM wavetable oscillator.
`default_nettype none

package fmwo_pkg;

    localparam int TABLE_BITS_DEF = 12;
    localparam int PHASE_BITS_DEF = 24;

    localparam int BASE_W   = 23;
    localparam int AMP_W    = 15;
    localparam int RATIO_W  = 16;
    localparam int VAL_W    = 16;
    localparam int ADDR_W   = 12;
    localparam int INC_W    = BASE_W + RATIO_W - 8;
    localparam int FMA_W    = INC_W + RATIO_W;
    localparam int FMA_LO_W = 24;
    localparam int FMA_HI_W = FMA_W - FMA_LO_W;
    localparam int FM_SHIFT = 23;
    localparam int AMP_SHIFT = 15;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = BASE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAR_RATIO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_RATIO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_INDEX = 3'd4;

    localparam logic [BASE_W-1:0]  RST_BASE_INC  = 23'd167393;
    localparam logic [AMP_W-1:0]   RST_AMPLITUDE = 15'd13107;
    localparam logic [RATIO_W-1:0] RST_CAR_RATIO = 16'd256;
    localparam logic [RATIO_W-1:0] RST_MOD_RATIO = 16'd256;
    localparam logic [RATIO_W-1:0] RST_MOD_INDEX = 16'd256;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic signed [VAL_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] SAMPLE_MIN = -16'sh8000;

endpackage

`default_nettype wire

>>> design/fm_wavetable_oscillator.sv
// Top level of the two-operator FM wavetable oscillator: sequencer, phases and registers.
//
// Channel  Dir  Handshake                 Contents
// s        in   i_s_tvalid / o_s_tready   tuser: kind; tdata: table_address, table_value
// m        out  o_m_tvalid / i_m_tready   tdata: sample
// cfg      in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A table write completes as it is accepted, in ST_IDLE. A tick makes four reads through
// the single table read port and eight products through the one shared multiplier.
// A tick waits in its last state, ST_OUT, while the previous sample has not been taken.
// Synchronous reset clears both phases and loads the register defaults; the table is
// not cleared.
`default_nettype none

module fm_wavetable_oscillator
    import fmwo_pkg::*;
#(
    parameter int TABLE_BITS = TABLE_BITS_DEF,
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_s_tvalid,
    output logic                    o_s_tready,
    input  wire  [S_DATA_W-1:0]     i_s_tdata,   // [11:0] table_address, [27:12] table_value
    input  wire                     i_s_tuser,   // [0] kind
    output logic                    o_m_tvalid,
    input  wire                     i_m_tready,
    output logic [M_DATA_W-1:0]     o_m_tdata,   // [15:0] sample
    input  wire                     i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int FRAC_BITS = PHASE_BITS - TABLE_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_MV,
        ST_CI, ST_LO, ST_HI, ST_AMP, ST_OUT
    } t_state;

    t_state r_state;

    logic [BASE_W-1:0]  r_base;
    logic [AMP_W-1:0]   r_amp;
    logic [RATIO_W-1:0] r_cratio;
    logic [RATIO_W-1:0] r_mratio;
    logic [RATIO_W-1:0] r_mindex;

    logic [PHASE_BITS-1:0] r_mod_phase;
    logic [PHASE_BITS-1:0] r_car_phase;

    logic [INC_W-1:0]      r_minc;
    logic [PHASE_BITS-1:0] r_cbase;
    logic signed [VAL_W-1:0] r_ma, r_mb, r_ca, r_cb;
    logic signed [VAL_W-1:0] r_mval, r_cval;
    logic [FMA_W-1:0]      r_fma;
    logic [PHASE_BITS-1:0] r_fm_lo;
    logic [PHASE_BITS-1:0] r_fm_hi;
    logic signed [VAL_W-1:0] r_sample;
    logic                  r_out_valid;

    logic                  w_s_acc;
    logic                  w_out_free;
    logic                  w_we;
    logic [TABLE_BITS-1:0] w_raddr;
    logic [VAL_W-1:0]      w_rdata;
    logic signed [MUL_A_W-1:0] w_a;
    logic signed [MUL_B_W-1:0] w_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_interp_sh;
    logic signed [PROD_W-1:0]  w_amp_sh;
    logic signed [VAL_W-1:0]   w_sat;
    logic signed [VAL_W:0]     w_mdiff;
    logic signed [VAL_W:0]     w_cdiff;
    logic [TABLE_BITS-1:0] w_midx, w_cidx;
    logic [FRAC_BITS-1:0]  w_mfr, w_cfr;
    logic [PHASE_BITS-1:0] w_cinc;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_we       = w_s_acc && (i_s_tuser == KIND_WRITE);
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_sample;

    assign w_midx = r_mod_phase[PHASE_BITS-1 -: TABLE_BITS];
    assign w_cidx = r_car_phase[PHASE_BITS-1 -: TABLE_BITS];
    assign w_mfr  = r_mod_phase[FRAC_BITS-1:0];
    assign w_cfr  = r_car_phase[FRAC_BITS-1:0];

    assign w_mdiff = (VAL_W+1)'(r_mb) - (VAL_W+1)'(r_ma);
    assign w_cdiff = (VAL_W+1)'(r_cb) - (VAL_W+1)'(r_ca);

    assign w_interp_sh = w_prod >>> FRAC_BITS;
    assign w_amp_sh    = w_prod >>> AMP_SHIFT;
    assign w_cinc      = r_cbase + r_fm_hi + r_fm_lo;

    always_comb begin
        if (w_amp_sh > PROD_W'(SAMPLE_MAX)) begin
            w_sat = SAMPLE_MAX;
        end else if (w_amp_sh < PROD_W'(SAMPLE_MIN)) begin
            w_sat = SAMPLE_MIN;
        end else begin
            w_sat = VAL_W'(w_amp_sh);
        end
    end

    always_comb begin
        w_raddr = w_midx;
        w_a     = '0;
        w_b     = '0;
        unique case (r_state)
            ST_RD0: begin
                w_raddr = w_midx;
                w_a     = MUL_A_W'(r_base);
                w_b     = MUL_B_W'(r_mratio);
            end
            ST_RD1: begin
                w_raddr = w_midx + TABLE_BITS'(1);
                w_a     = MUL_A_W'(r_base);
                w_b     = MUL_B_W'(r_cratio);
            end
            ST_RD2: begin
                w_raddr = w_cidx;
            end
            ST_RD3: begin
                w_raddr = w_cidx + TABLE_BITS'(1);
                w_a     = MUL_A_W'(w_mfr);
                w_b     = MUL_B_W'(w_mdiff);
            end
            ST_MV: begin
                w_a = MUL_A_W'(r_minc);
                w_b = MUL_B_W'(r_mindex);
            end
            ST_CI: begin
                w_a = MUL_A_W'(w_cfr);
                w_b = MUL_B_W'(w_cdiff);
            end
            ST_LO: begin
                w_a = MUL_A_W'(r_fma[FMA_LO_W-1:0]);
                w_b = MUL_B_W'(r_mval);
            end
            ST_HI: begin
                w_a = MUL_A_W'(r_fma[FMA_W-1:FMA_LO_W]);
                w_b = MUL_B_W'(r_mval);
            end
            ST_AMP, ST_OUT: begin
                w_a = MUL_A_W'(r_amp);
                w_b = MUL_B_W'(r_cval);
            end
            default: begin
                w_raddr = w_midx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_mod_phase <= '0;
            r_car_phase <= '0;
            r_base      <= RST_BASE_INC;
            r_amp       <= RST_AMPLITUDE;
            r_cratio    <= RST_CAR_RATIO;
            r_mratio    <= RST_MOD_RATIO;
            r_mindex    <= RST_MOD_INDEX;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BASE_INC:  r_base   <= i_cfg_data;
                    CFG_AMPLITUDE: r_amp    <= i_cfg_data[AMP_W-1:0];
                    CFG_CAR_RATIO: r_cratio <= i_cfg_data[RATIO_W-1:0];
                    CFG_MOD_RATIO: r_mratio <= i_cfg_data[RATIO_W-1:0];
                    CFG_MOD_INDEX: r_mindex <= i_cfg_data[RATIO_W-1:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_m_tready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_s_acc && (i_s_tuser == KIND_TICK)) begin
                        r_state <= ST_RD0;
                    end
                end
                ST_RD0: r_state <= ST_RD1;
                ST_RD1: begin
                    r_ma    <= w_rdata;
                    r_minc  <= w_prod[INC_W+7:8];
                    r_state <= ST_RD2;
                end
                ST_RD2: begin
                    r_mb    <= w_rdata;
                    r_cbase <= w_prod[PHASE_BITS+7:8];
                    r_state <= ST_RD3;
                end
                ST_RD3: begin
                    r_ca    <= w_rdata;
                    r_state <= ST_MV;
                end
                ST_MV: begin
                    r_cb    <= w_rdata;
                    r_mval  <= r_ma + VAL_W'(w_interp_sh);
                    r_state <= ST_CI;
                end
                ST_CI: begin
                    r_fma   <= w_prod[FMA_W-1:0];
                    r_state <= ST_LO;
                end
                ST_LO: begin
                    r_cval  <= r_ca + VAL_W'(w_interp_sh);
                    r_state <= ST_HI;
                end
                ST_HI: begin
                    r_fm_lo <= PHASE_BITS'(w_prod >>> FM_SHIFT);
                    r_state <= ST_AMP;
                end
                ST_AMP: begin
                    r_fm_hi <= PHASE_BITS'(w_prod <<< (FMA_LO_W - FM_SHIFT));
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_sample    <= w_sat;
                        r_out_valid <= 1'b1;
                        r_mod_phase <= r_mod_phase + PHASE_BITS'(r_minc);
                        r_car_phase <= r_car_phase + w_cinc;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    fmwo_table #(
        .TABLE_BITS (TABLE_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (TABLE_BITS'(i_s_tdata[ADDR_W-1:0])),
        .i_wdata (i_s_tdata[ADDR_W +: VAL_W]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fmwo_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

endmodule

`default_nettype wire

>>> design/fmwo_table.sv
// Wavetable memory: one write port, one read port with registered read data.
`default_nettype none

module fmwo_table
    import fmwo_pkg::*;
#(
    parameter int TABLE_BITS = TABLE_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire  [TABLE_BITS-1:0]   i_waddr,
    input  wire  [VAL_W-1:0]        i_wdata,
    input  wire  [TABLE_BITS-1:0]   i_raddr,
    output logic [VAL_W-1:0]        o_rdata
);

    logic [VAL_W-1:0] r_mem [2**TABLE_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/fmwo_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module fmwo_mul
    import fmwo_pkg::*;
(
    input  wire                        i_clk,
    input  wire  signed [MUL_A_W-1:0]  i_a,
    input  wire  signed [MUL_B_W-1:0]  i_b,
    output logic signed [PROD_W-1:0]   o_prod
);

    always_ff @(posedge i_clk) begin
        o_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the FM wavetable oscillator: stimulus, model and scoreboard.
module tb_top;
    import fmwo_pkg::*;

    localparam int PH_W = PHASE_BITS_DEF;
    localparam int FR_W = PHASE_BITS_DEF - ADDR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef enum logic [1:0] {ROW_WRITE, ROW_TICK, ROW_REG} t_row_op;

    typedef struct {
        t_row_op                 op;
        logic [ADDR_W-1:0]       addr;
        logic signed [VAL_W-1:0] value;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_data;
        bit                      typed;
        logic signed [VAL_W-1:0] want;
    } t_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata  = '0;   // [11:0] table_address, [27:12] table_value
    logic                  i_s_tuser  = 1'b0; // [0] kind
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;         // [15:0] sample
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic signed [VAL_W-1:0] wave_mem [1 << ADDR_W];
    logic [PH_W-1:0]         mod_ph;
    logic [PH_W-1:0]         car_ph;
    logic [BASE_W-1:0]       base_inc;
    logic [AMP_W-1:0]        amp_gain;
    logic [RATIO_W-1:0]      car_ratio;
    logic [RATIO_W-1:0]      mod_ratio;
    logic [RATIO_W-1:0]      mod_depth;

    logic signed [VAL_W-1:0] sample_q [$];
    t_row                    dir_rows [$];
    int                      samples_seen = 0;
    int                      mismatches   = 0;
    int                      burst_left   = 0;

    fm_wavetable_oscillator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint table_lerp(logic [PH_W-1:0] ph);
        logic [ADDR_W-1:0] idx;
        logic [ADDR_W-1:0] nxt;
        longint            lo;
        longint            hi;
        longint            fr;
        idx = ph[PH_W-1 -: ADDR_W];
        nxt = idx + ADDR_W'(1);
        lo  = longint'(wave_mem[idx]);
        hi  = longint'(wave_mem[nxt]);
        fr  = longint'(ph[FR_W-1:0]);
        return lo + (((hi - lo) * fr) >>> FR_W);
    endfunction

    // compute the sample for one tick and advance both phases
    function automatic logic signed [VAL_W-1:0] next_sample();
        longint minc;
        longint cbase;
        longint mval;
        longint fm;
        longint cinc;
        longint cval;
        longint s;
        minc   = (longint'(base_inc) * longint'(mod_ratio)) >>> 8;
        cbase  = (longint'(base_inc) * longint'(car_ratio)) >>> 8;
        mval   = table_lerp(mod_ph);
        fm     = (longint'(mod_depth) * minc * mval) >>> FM_SHIFT;
        cinc   = cbase + fm;
        mod_ph = mod_ph + minc[PH_W-1:0];
        cval   = table_lerp(car_ph);
        s      = (cval * longint'(amp_gain)) >>> AMP_SHIFT;
        car_ph = car_ph + cinc[PH_W-1:0];
        if (s > longint'(SAMPLE_MAX)) begin
            return SAMPLE_MAX;
        end
        if (s < longint'(SAMPLE_MIN)) begin
            return SAMPLE_MIN;
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_BASE_INC:  base_inc  = data[BASE_W-1:0];
            CFG_AMPLITUDE: amp_gain  = data[AMP_W-1:0];
            CFG_CAR_RATIO: car_ratio = data[RATIO_W-1:0];
            CFG_MOD_RATIO: mod_ratio = data[RATIO_W-1:0];
            CFG_MOD_INDEX: mod_depth = data[RATIO_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_row mk_row(t_row_op op, logic [ADDR_W-1:0] addr,
                                    logic signed [VAL_W-1:0] value,
                                    logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data,
                                    bit typed, logic signed [VAL_W-1:0] want);
        t_row r;
        r.op       = op;
        r.addr     = addr;
        r.value    = value;
        r.reg_idx  = idx;
        r.reg_data = data;
        r.typed    = typed;
        r.want     = want;
        return r;
    endfunction

    task automatic report(string what, logic signed [VAL_W-1:0] exp_v,
                          logic signed [VAL_W-1:0] act_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t ns: %s: expected %0d, got %0d", $time, what, exp_v, act_v);
        end
    endtask

    task automatic send_item(logic kind, logic [ADDR_W-1:0] addr,
                             logic signed [VAL_W-1:0] value,
                             bit typed, logic signed [VAL_W-1:0] want);
        logic signed [VAL_W-1:0] s;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {{(S_DATA_W - ADDR_W - VAL_W){1'b0}}, value, addr};
        do @(posedge i_clk); while (!o_s_tready);
        if (kind == KIND_WRITE) begin
            wave_mem[addr] = value;
        end else begin
            s = next_sample();
            sample_q.push_back(typed ? want : s);
        end
    endtask

    // drop valid, then wait for every sample and for the block to settle
    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        load_reg(idx, data);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
    endtask

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic program_voice(int mode);
        logic [BASE_W-1:0]  nb;
        logic [AMP_W-1:0]   na;
        logic [RATIO_W-1:0] ncr;
        logic [RATIO_W-1:0] nmr;
        logic [RATIO_W-1:0] nmi;
        case (mode)
            0: begin
                nb = RST_BASE_INC; na = RST_AMPLITUDE;
                ncr = RST_CAR_RATIO; nmr = RST_MOD_RATIO; nmi = RST_MOD_INDEX;
            end
            1: begin
                nb = '1; na = '1; ncr = '1; nmr = '1; nmi = '1;
            end
            2: begin
                nb = '0; na = '0; ncr = '0; nmr = '0; nmi = '0;
            end
            3: begin
                nb = BASE_W'($urandom); na = AMP_W'($urandom);
                ncr = RATIO_W'($urandom); nmr = RATIO_W'($urandom); nmi = RATIO_W'($urandom);
            end
            default: begin
                nb  = BASE_W'($urandom_range(1000, 400000));
                na  = AMP_W'($urandom);
                ncr = RATIO_W'($urandom_range(64, 1024));
                nmr = RATIO_W'($urandom_range(64, 1024));
                nmi = RATIO_W'($urandom_range(0, 2048));
            end
        endcase
        write_reg(CFG_BASE_INC, nb);
        write_reg(CFG_AMPLITUDE, {8'($urandom), na});
        write_reg(CFG_CAR_RATIO, {7'($urandom), ncr});
        write_reg(CFG_MOD_RATIO, {7'($urandom), nmr});
        write_reg(CFG_MOD_INDEX, {7'($urandom), nmi});
        if ($urandom_range(0, 1) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                      CFG_DATA_W'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            samples_seen++;
            if (sample_q.size() == 0) begin
                report("sample with none expected", '0, o_m_tdata);
            end else if (sample_q[0] !== o_m_tdata) begin
                report("sample mismatch", sample_q[0], o_m_tdata);
                void'(sample_q.pop_front());
            end else begin
                void'(sample_q.pop_front());
            end
        end
    end

    initial begin : receiver
        logic [31:0] pat;
        int          left;
        int          mode;
        bit          held;
        pat  = '1;
        left = 0;
        mode = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && samples_seen >= 120) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (600) @(negedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    pat  = $urandom;
                    left = 32;
                end
                case (mode)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= pat[0];
                    2: i_m_tready <= pat[0] & pat[1];
                    default: i_m_tready <= pat[0] | pat[1];
                endcase
                pat = {pat[0], pat[31:1]};
                left--;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int a;
        int n;
        int ph;
        int waited;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        mod_ph = '0;
        car_ph = '0;
        load_reg(CFG_BASE_INC, RST_BASE_INC);
        load_reg(CFG_AMPLITUDE, RST_AMPLITUDE);
        load_reg(CFG_CAR_RATIO, RST_CAR_RATIO);
        load_reg(CFG_MOD_RATIO, RST_MOD_RATIO);
        load_reg(CFG_MOD_INDEX, RST_MOD_INDEX);

        // fill the whole table before any tick
        for (a = 0; a < (1 << ADDR_W); a++) begin
            pace_sender();
            send_item(KIND_WRITE, ADDR_W'(a), rand_value(), 1'b0, '0);
        end

        dir_rows.push_back(mk_row(ROW_WRITE, 12'd0, SAMPLE_MAX, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_WRITE, 12'd1, 16'sd0, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_WRITE, 12'd4095, SAMPLE_MIN, '0, '0, 1'b0, '0));
        // upper data bits must be dropped
        dir_rows.push_back(mk_row(ROW_REG, '0, '0, CFG_AMPLITUDE, 23'h7FFFFF, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_REG, '0, '0, CFG_MOD_INDEX, 23'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_REG, '0, '0, CFG_BASE_INC, 23'h7FFFFF, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_REG, '0, '0, CFG_CAR_RATIO, 23'd512, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_REG, '0, '0, CFG_MOD_RATIO, 23'd0, 1'b0, '0));
        // phases at zero read entry 0 at full gain
        dir_rows.push_back(mk_row(ROW_TICK, '0, '0, '0, '0, 1'b1, 16'sd32766));
        // carrier now sits in the last entry: neighbour wraps to entry 0
        dir_rows.push_back(mk_row(ROW_TICK, '0, '0, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_TICK, '0, '0, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_REG, '0, '0, CFG_UNUSED_LO, 23'h123456, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_REG, '0, '0, CFG_UNUSED_HI, 23'h7FFFFF, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_TICK, '0, '0, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_REG, '0, '0, CFG_AMPLITUDE, 23'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_TICK, '0, '0, '0, '0, 1'b1, 16'sd0));
        dir_rows.push_back(mk_row(ROW_REG, '0, '0, CFG_AMPLITUDE, 23'd32767, 1'b0, '0));
        // deep modulation, no carrier base: increments go negative and oversized
        dir_rows.push_back(mk_row(ROW_REG, '0, '0, CFG_MOD_RATIO, 23'hFFFF, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_REG, '0, '0, CFG_MOD_INDEX, 23'hFFFF, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_REG, '0, '0, CFG_CAR_RATIO, 23'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_TICK, '0, '0, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_TICK, '0, '0, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_TICK, '0, '0, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_WRITE, 12'd4095, SAMPLE_MAX, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_TICK, 12'hFFF, SAMPLE_MIN, '0, '0, 1'b0, '0));

        foreach (dir_rows[r]) begin
            case (dir_rows[r].op)
                ROW_REG: begin
                    drain_results();
                    write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_data);
                end
                ROW_WRITE: send_item(KIND_WRITE, dir_rows[r].addr, dir_rows[r].value,
                                     1'b0, '0);
                default: send_item(KIND_TICK, dir_rows[r].addr, dir_rows[r].value,
                                   dir_rows[r].typed, dir_rows[r].want);
            endcase
        end

        for (ph = 0; ph < 8; ph++) begin
            drain_results();
            case (ph)
                0: program_voice(4);
                1: program_voice(1);
                2: program_voice(3);
                3: program_voice(2);
                4: program_voice(0);
                default: program_voice($urandom_range(0, 4));
            endcase
            burst_left = 0;
            for (n = 0; n < 78; n++) begin
                pace_sender();
                if ($urandom_range(0, 3) == 0) begin
                    send_item(KIND_WRITE, ADDR_W'($urandom), rand_value(), 1'b0, '0);
                end else begin
                    send_item(KIND_TICK, ADDR_W'($urandom), rand_value(), 1'b0, '0);
                end
            end
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        waited = 0;
        while (sample_q.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (32) @(posedge i_clk);
        if (sample_q.size() != 0) begin
            report("samples never delivered", sample_q[0], '0);
        end
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
